>>> rtl/core/sbus_frame_decoder_core_macros.svh
// Assertion macros shared by the frame decoder RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef SBUS_FRAME_DECODER_CORE_MACROS_SVH
`define SBUS_FRAME_DECODER_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SBUSD_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define SBUSD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/core/sbusd_pkg.sv
// Types and constants of the frame decoder.
// No dependencies; used by every other file of the block but the macro header.
package sbusd_pkg;

  localparam logic [7:0] HDR_BYTE   = 8'h0F;
  localparam logic [7:0] END_BYTE   = 8'h00;
  localparam int         CH_BITS    = 11;
  localparam int         CH_COUNT   = 16;
  localparam int         DATA_BITS  = 176;
  localparam int         STORE_LEN  = 23;
  localparam int         STORE_BITS = STORE_LEN * 8;
  localparam logic [4:0] LAST_POS   = 5'd24;
  localparam int         LOST_BIT   = 2;
  localparam int         FS_BIT     = 3;

  localparam logic [1:0] LINK_OK       = 2'd0;
  localparam logic [1:0] LINK_LOST     = 2'd1;
  localparam logic [1:0] LINK_FAILSAFE = 2'd2;

  // Command from the byte front end to the result back end.
  typedef enum logic {
    CMD_WRITE = 1'b0,  // shift one frame byte into the store
    CMD_EMIT  = 1'b1   // frame complete: send its 16 channels
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t  kind;
    logic [7:0] data;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } cmd_push_t;

endpackage

>>> rtl/core/sbusd_if.sv
// Valid/ready channel interfaces of the frame decoder.
// Depends on sbusd_pkg (widths follow the package constants).
interface sbusd_in_if import sbusd_pkg::*;;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       burst_end;

  modport source (output valid, output rx_byte, output burst_end, input ready);
  modport sink   (input valid, input rx_byte, input burst_end, output ready);
endinterface

interface sbusd_out_if import sbusd_pkg::*;;
  logic               valid;
  logic               ready;
  logic [3:0]         channel_index;
  logic [CH_BITS-1:0] channel_value;
  logic               digital_one;
  logic               digital_two;
  logic [1:0]         link_status;
  logic               last_of_frame;

  modport source (output valid, output channel_index, output channel_value,
                  output digital_one, output digital_two, output link_status,
                  output last_of_frame, input ready);
  modport sink   (input valid, input channel_index, input channel_value,
                  input digital_one, input digital_two, input link_status,
                  input last_of_frame, output ready);
endinterface

>>> rtl/core/sbus_frame_decoder_core.sv
// Top level of the 16-channel serial receiver frame decoder.
// Depends on sbusd_pkg, sbusd_if, sbusd_front, sbusd_fifo and sbusd_back.
//
// Usage:
//  - byte_ch takes one received UART byte per transfer with its burst_end
//    mark (1 = receive buffer empty after this byte).
//  - A frame is header 0x0F, 22 data bytes, a flag byte and end byte 0x00.
//    Non-header bytes in idle are dropped through the end of their burst;
//    a burst_end before byte 24 aborts the frame.
//  - result_ch gives 16 transfers per good frame, channel 0 to 15, each with
//    the two digital flags and link status; last_of_frame marks channel 15.
// Timing:
//  - A byte is taken whenever the command queue has room.
//  - The end byte's command passes through the queue, sets the back end's
//    emitting flag and then loads the output register; then one result
//    per cycle while result_ch is ready, from the single channel unpacker.
//  - While the back end emits, the front end keeps taking bytes into the
//    QUEUE_DEPTH-entry queue; a full queue drops byte_ch.ready.
// Reset: rst (synchronous) returns the sync machine to idle, empties the
//  queue and clears the output valid. A stalled result_ch holds its
//  transfer and stops the unpacker; the queue then fills and stalls byte_ch.
module sbus_frame_decoder_core import sbusd_pkg::*; #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  sbusd_in_if.sink    byte_ch,
  sbusd_out_if.source result_ch
);

  cmd_push_t push;
  logic      q_full;
  logic      q_empty;
  logic      q_pop;
  cmd_t      q_head;

  // front end: frame sync, one command per useful byte
  sbusd_front u_front (
    .clk    (clk),
    .rst    (rst),
    .rx     (byte_ch),
    .q_full (q_full),
    .push   (push)
  );

  // decouples byte intake from result emission
  sbusd_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .full  (q_full),
    .empty (q_empty),
    .head  (q_head),
    .pop   (q_pop)
  );

  // back end: byte store and 11-bit channel unpacking
  sbusd_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .q_head  (q_head),
    .q_pop   (q_pop),
    .res     (result_ch)
  );

endmodule

>>> rtl/core/sbusd_front.sv
// Byte front end: frame sync state machine, turns bytes into store commands.
// Depends on sbusd_pkg and sbusd_if.
module sbusd_front import sbusd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  sbusd_in_if.sink   rx,
  input  logic       q_full,
  output cmd_push_t  push
);

  typedef enum logic [2:0] {
    MODE_IDLE = 3'b001,
    MODE_RECV = 3'b010,
    MODE_DROP = 3'b100
  } mode_t;

  mode_t      mode, mode_next;
  logic [4:0] pos, pos_next;
  logic       take;
  logic [4:0] pos_inc;

  assign rx.ready = !q_full;
  assign take     = rx.valid && rx.ready;
  assign pos_inc  = pos + 5'd1;

  always_comb begin
    mode_next       = mode;
    pos_next        = pos;
    push.valid      = 1'b0;
    push.cmd.kind   = CMD_WRITE;
    push.cmd.data   = rx.rx_byte;
    if (take) begin
      case (mode)
        MODE_DROP: begin
          if (rx.burst_end) mode_next = MODE_IDLE;
        end
        MODE_RECV: begin
          pos_next = pos_inc;
          if (pos_inc < LAST_POS) begin
            push.valid = 1'b1;
            if (rx.burst_end) mode_next = MODE_IDLE;
          end else begin
            mode_next = MODE_IDLE;
            // end byte must be zero for the frame to count
            if (pos_inc == LAST_POS && rx.rx_byte == END_BYTE) begin
              push.valid    = 1'b1;
              push.cmd.kind = CMD_EMIT;
            end
          end
        end
        default: begin
          if (rx.rx_byte != HDR_BYTE) begin
            mode_next = rx.burst_end ? MODE_IDLE : MODE_DROP;
          end else begin
            pos_next  = 5'd0;
            mode_next = rx.burst_end ? MODE_IDLE : MODE_RECV;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_IDLE;
      pos  <= 5'd0;
    end else begin
      mode <= mode_next;
      pos  <= pos_next;
    end
  end

endmodule

>>> rtl/core/sbusd_fifo.sv
// Short command queue between the front end and the back end.
// Depends on sbusd_pkg and the assertion macro header.
`include "sbus_frame_decoder_core_macros.svh"

module sbusd_fifo import sbusd_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic      clk,
  input  logic      rst,
  input  cmd_push_t push,
  output logic      full,
  output logic      empty,
  output cmd_t      head,
  input  logic      pop
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_SLOT = PW'(DEPTH - 1);

  cmd_t          mem [DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;
  logic          do_push, do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign head    = mem[rd_ptr];
  assign do_push = push.valid && !full;
  assign do_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr] <= push.cmd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= (wr_ptr == LAST_SLOT) ? '0 : wr_ptr + PW'(1);
      if (do_pop)  rd_ptr <= (rd_ptr == LAST_SLOT) ? '0 : rd_ptr + PW'(1);
      case ({do_push, do_pop})
        2'b10:   count <= count + CW'(1);
        2'b01:   count <= count - CW'(1);
        default: count <= count;
      endcase
    end
  end

  `SBUSD_ASSERT_NOW(a_no_push_full, clk, rst, push.valid, !full, "push into full queue")
  `SBUSD_ASSERT_NOW(a_count_bound, clk, rst, 1'b1, count <= CW'(DEPTH), "queue count overflow")

endmodule

>>> rtl/core/sbusd_back.sv
// Back end: frame byte shift store and channel unpacker with output register.
// Depends on sbusd_pkg, sbusd_if and the assertion macro header.
`include "sbus_frame_decoder_core_macros.svh"

module sbusd_back import sbusd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        q_empty,
  input  cmd_t        q_head,
  output logic        q_pop,
  sbusd_out_if.source res
);

  logic [STORE_BITS-1:0] store;
  logic                  emitting;
  logic [3:0]            ch_cnt;
  logic                  load;
  logic [7:0]            flags;
  logic [1:0]            link;

  logic                  out_valid;
  logic [3:0]            out_index;
  logic [CH_BITS-1:0]    out_value;
  logic                  out_d1, out_d2, out_last;
  logic [1:0]            out_link;

  // flag byte sits at the top after 23 byte shifts
  assign flags = store[STORE_BITS-1 -: 8];
  assign load  = emitting && (!out_valid || res.ready);
  assign q_pop = !emitting && !q_empty;

  always_comb begin
    link = LINK_OK;
    if (flags[LOST_BIT]) link = LINK_LOST;
    if (flags[FS_BIT])   link = LINK_FAILSAFE;
  end

  always_ff @(posedge clk) begin
    if (q_pop && q_head.kind == CMD_WRITE) begin
      store <= {q_head.data, store[STORE_BITS-1:8]};
    end else if (load) begin
      store[DATA_BITS-1:0] <= {{CH_BITS{1'b0}}, store[DATA_BITS-1:CH_BITS]};
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_index <= ch_cnt;
      out_value <= store[CH_BITS-1:0];
      out_d1    <= flags[0];
      out_d2    <= flags[1];
      out_link  <= link;
      out_last  <= (ch_cnt == 4'(CH_COUNT - 1));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      emitting  <= 1'b0;
      ch_cnt    <= 4'd0;
      out_valid <= 1'b0;
    end else begin
      if (q_pop && q_head.kind == CMD_EMIT) begin
        emitting <= 1'b1;
        ch_cnt   <= 4'd0;
      end
      if (load) begin
        ch_cnt <= ch_cnt + 4'd1;
        if (ch_cnt == 4'(CH_COUNT - 1)) emitting <= 1'b0;
      end
      if (load)           out_valid <= 1'b1;
      else if (res.ready) out_valid <= 1'b0;
    end
  end

  assign res.valid         = out_valid;
  assign res.channel_index = out_index;
  assign res.channel_value = out_value;
  assign res.digital_one   = out_d1;
  assign res.digital_two   = out_d2;
  assign res.link_status   = out_link;
  assign res.last_of_frame = out_last;

  `SBUSD_ASSERT_NEXT(a_emit_ends, clk, rst, load && ch_cnt == 4'(CH_COUNT - 1), !emitting, "emit did not stop after last channel")
  `SBUSD_ASSERT_NOW(a_no_pop_emit, clk, rst, emitting, !q_pop, "queue popped during emit")
  `SBUSD_ASSERT_NEXT(a_hold_stall, clk, rst, out_valid && !res.ready, out_valid, "result dropped while stalled")

endmodule

>>> verif/sbus_frame_decoder_core_tb.sv
`timescale 1ns / 100ps
// Self-checking bench for sbus_frame_decoder_core: random serial byte bursts in,
// decoded channel transfers checked against an in-bench frame decoder.
// Depends on sbusd_pkg, sbusd_if and the core RTL.
module sbus_frame_decoder_core_tb;
  import sbusd_pkg::*;

  // Cycles with no transfer on either channel before the run is declared hung.
  // Worst correct case is a full command queue behind a 16-result frame whose
  // sink stalls ~37% of cycles; that stays well under the limit.
  localparam int STALL_LIMIT  = 2000;
  // Settle time after the last expected channel: covers the end byte's path
  // to the first result, plus a queue's worth of slack.
  localparam int DRAIN_CYCLES = 40;
  localparam int BYTE_TARGET  = 470;
  localparam int IDLE_PCT     = 37;

  // Receiver sync state, mirrored from the block's behavior.
  typedef enum logic [1:0] {
    SYNC_IDLE = 2'd0,
    SYNC_RECV = 2'd1,
    SYNC_DROP = 2'd2
  } sync_state_t;

  // Data fill styles for generated frames.
  typedef enum int {
    FILL_RANDOM = 0,
    FILL_ZEROS  = 1,
    FILL_ONES   = 2,
    FILL_CHECK  = 3
  } frame_fill_t;

  typedef struct {
    logic [7:0] rx_byte;
    logic       burst_end;
    bit         wait_idle;  // hold off until every pending channel is out
  } rx_item_t;

  typedef struct packed {
    logic [3:0]         index;
    logic [CH_BITS-1:0] value;
    logic               dig_one;
    logic               dig_two;
    logic [1:0]         link;
    logic               last;
  } channel_t;

  logic clk;
  logic rst;

  sbusd_in_if  byte_ch ();
  sbusd_out_if result_ch ();

  sbus_frame_decoder_core DUT (
    .clk       (clk),
    .rst       (rst),
    .byte_ch   (byte_ch),
    .result_ch (result_ch)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Stimulus bytes waiting for the driver, and channels still owed by the DUT.
  rx_item_t   rx_pending[$];
  channel_t   channels_due[$];

  // Local copy of the decoder state.
  sync_state_t sync_state;
  logic [4:0]  frame_pos;
  logic [7:0]  frame_store[STORE_LEN];

  int bytes_planned;
  int bytes_taken;
  int frames_decoded;
  int channels_checked;
  int mismatches;
  int holdoffs;
  int quiet_cycles;
  bit steady;  // both sides run without idling

  // No idling in a middle stretch of the run so back-to-back frames hit the
  // queue-full path.
  assign steady = (bytes_taken >= 150) && (bytes_taken < 260);

  // ---------------------------------------------------------------------------
  // Frame decoder: one byte in, zero or sixteen channels out.
  // ---------------------------------------------------------------------------
  function automatic void decode_byte(input logic [7:0] rx, input logic gap);
    channel_t   ch;
    logic [7:0] flags;
    int         k;
    int         j;
    int         bit_ix;
    case (sync_state)
      SYNC_DROP: begin
        // Drop everything, headers too, until the burst runs dry.
        if (gap) sync_state = SYNC_IDLE;
      end
      SYNC_RECV: begin
        frame_pos = frame_pos + 5'd1;
        if (frame_pos >= 5'd1 && frame_pos <= 5'(STORE_LEN))
          frame_store[frame_pos - 5'd1] = rx;
        if (frame_pos < LAST_POS) begin
          // A gap before the end byte aborts the frame.
          if (gap) sync_state = SYNC_IDLE;
        end else begin
          sync_state = SYNC_IDLE;
          if (frame_pos == LAST_POS && rx == END_BYTE) begin
            flags = frame_store[STORE_LEN - 1];
            for (k = 0; k < CH_COUNT; k++) begin
              ch.index = 4'(k);
              ch.value = '0;
              // Channels are packed LSB first across the data bytes.
              for (j = 0; j < CH_BITS; j++) begin
                bit_ix = k * CH_BITS + j;
                ch.value[j] = frame_store[bit_ix / 8][bit_ix % 8];
              end
              ch.dig_one = flags[0];
              ch.dig_two = flags[1];
              // Failsafe outranks signal lost.
              if (flags[FS_BIT])
                ch.link = LINK_FAILSAFE;
              else if (flags[LOST_BIT])
                ch.link = LINK_LOST;
              else
                ch.link = LINK_OK;
              ch.last = (k == CH_COUNT - 1);
              channels_due.push_back(ch);
            end
            frames_decoded++;
          end
        end
      end
      default: begin
        if (rx != HDR_BYTE) begin
          sync_state = gap ? SYNC_IDLE : SYNC_DROP;
        end else begin
          frame_pos  = 5'd0;
          sync_state = gap ? SYNC_IDLE : SYNC_RECV;
        end
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus builders
  // ---------------------------------------------------------------------------
  task automatic add_byte(input logic [7:0] rx, input logic gap,
                          input bit wait_idle = 1'b0, input bit counted = 1'b1);
    rx_item_t item;
    item.rx_byte   = rx;
    item.burst_end = gap;
    item.wait_idle = wait_idle;
    rx_pending.push_back(item);
    if (counted) bytes_planned++;
  endtask

  // Header, 22 data bytes and flag byte all inside one burst, then the end byte.
  task automatic add_frame(input frame_fill_t fill, input logic [7:0] flags,
                           input logic [7:0] end_byte, input logic end_gap,
                           input bit wait_idle);
    int         n;
    logic [7:0] d;
    add_byte(HDR_BYTE, 1'b0, wait_idle);
    for (n = 0; n < 22; n++) begin
      case (fill)
        FILL_ZEROS: d = 8'h00;
        FILL_ONES:  d = 8'hFF;
        FILL_CHECK: d = n[0] ? 8'h55 : 8'hAA;
        default:    d = 8'($urandom_range(255));
      endcase
      add_byte(d, 1'b0);
    end
    add_byte(flags, 1'b0);
    add_byte(end_byte, end_gap);
  endtask

  // Header then 1..23 bytes, the last of which ends the burst early.
  task automatic add_cut_frame();
    int n;
    int cut;
    cut = $urandom_range(23, 1);
    add_byte(HDR_BYTE, 1'b0);
    for (n = 1; n <= cut; n++)
      add_byte(8'($urandom_range(255)), (n == cut));
  endtask

  // Short junk burst; always closes with a burst end so the decoder resyncs.
  task automatic add_noise();
    int n;
    int len;
    len = $urandom_range(6, 1);
    for (n = 1; n <= len; n++)
      add_byte(8'($urandom_range(255)), (n == len) ? 1'b1 : 1'($urandom_range(1)),
               1'b0, 1'b0);
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Byte driver: presents queued bytes, predicts on every accepted transfer.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : byte_driver
    logic     next_valid;
    rx_item_t item;
    if (rst) begin
      byte_ch.valid <= 1'b0;
    end else begin
      next_valid = byte_ch.valid;
      if (byte_ch.valid && byte_ch.ready) begin
        decode_byte(byte_ch.rx_byte, byte_ch.burst_end);
        bytes_taken++;
        next_valid = 1'b0;
      end
      if (!next_valid && rx_pending.size() != 0) begin
        if (rx_pending[0].wait_idle && channels_due.size() != 0) begin
          // Hold off: let the back end drain completely first.
        end else if (!steady && $urandom_range(99) < IDLE_PCT) begin
          // Random idle cycle.
        end else begin
          item = rx_pending.pop_front();
          if (item.wait_idle) holdoffs++;
          byte_ch.rx_byte   <= item.rx_byte;
          byte_ch.burst_end <= item.burst_end;
          next_valid = 1'b1;
        end
      end
      byte_ch.valid <= next_valid;
    end
  end

  // ---------------------------------------------------------------------------
  // Result monitor: random backpressure, in-order compare of every transfer.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : channel_monitor
    channel_t want;
    if (rst) begin
      result_ch.ready <= 1'b0;
    end else begin
      if (result_ch.valid && result_ch.ready) begin
        if (channels_due.size() == 0) begin
          $display("%0t: unexpected channel transfer: expected none, actual ch %0d = %0d",
                   $time, result_ch.channel_index, result_ch.channel_value);
          mismatches++;
        end else begin
          want = channels_due.pop_front();
          check_field("channel_index", want.index, result_ch.channel_index);
          check_field("channel_value", want.value, result_ch.channel_value);
          check_field("digital_one",   want.dig_one, result_ch.digital_one);
          check_field("digital_two",   want.dig_two, result_ch.digital_two);
          check_field("link_status",   want.link, result_ch.link_status);
          check_field("last_of_frame", want.last, result_ch.last_of_frame);
          channels_checked++;
        end
      end
      result_ch.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Watchdog: any cycle with a transfer on either side restarts the count.
  always @(posedge clk) begin
    if (rst || (byte_ch.valid && byte_ch.ready) || (result_ch.valid && result_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no transfer for %0d cycles, %0d channels still due",
               $time, STALL_LIMIT, channels_due.size());
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence: reset, directed bytes, random traffic, drain, verdict.
  // ---------------------------------------------------------------------------
  initial begin
    int          frame_no;
    int          pick;
    frame_fill_t fill;
    logic [7:0]  end_byte;

    rst                 = 1'b1;
    byte_ch.valid       = 1'b0;
    byte_ch.rx_byte     = 8'h00;
    byte_ch.burst_end   = 1'b0;
    result_ch.ready     = 1'b0;
    sync_state          = SYNC_IDLE;
    frame_pos           = 5'd0;
    bytes_planned       = 0;
    bytes_taken         = 0;
    frames_decoded      = 0;
    channels_checked    = 0;
    mismatches          = 0;
    holdoffs            = 0;
    quiet_cycles        = 0;
    foreach (frame_store[i]) frame_store[i] = 8'h00;

    // Directed: idle junk with and without a gap, header ignored while
    // dropping, lone header ended by a gap, frame cut right after its header,
    // then a full all-ones frame with every flag bit set (failsafe over lost),
    // and a checkerboard frame with only signal lost that waits for the
    // previous frame's channels to drain first.
    add_byte(8'h00, 1'b1);
    add_byte(8'hFF, 1'b0);
    add_byte(HDR_BYTE, 1'b0);
    add_byte(8'h55, 1'b1);
    add_byte(HDR_BYTE, 1'b1);
    add_byte(HDR_BYTE, 1'b0);
    add_byte(8'h12, 1'b1);
    add_frame(FILL_ONES, 8'h0F, END_BYTE, 1'b1, 1'b1);
    add_frame(FILL_CHECK, 8'h04, END_BYTE, 1'b0, 1'b1);

    // Random: mostly clean frames, some cut short, some junk between them.
    frame_no = 0;
    while (bytes_planned < BYTE_TARGET) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        case ($urandom_range(9))
          0:       fill = FILL_ZEROS;
          1:       fill = FILL_ONES;
          2:       fill = FILL_CHECK;
          default: fill = FILL_RANDOM;
        endcase
        // Mostly a proper end byte; the rest must yield no channels.
        end_byte = ($urandom_range(99) < 85) ? END_BYTE : 8'($urandom_range(255, 1));
        add_frame(fill, 8'($urandom_range(255)), end_byte, 1'($urandom_range(1)),
                  (frame_no % 6 == 5));
        frame_no++;
      end else if (pick < 85) begin
        add_cut_frame();
      end else begin
        add_noise();
      end
    end

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    do @(posedge clk);
    while (rx_pending.size() != 0 || byte_ch.valid || channels_due.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run covered %0d bytes (clean, cut and junk bursts, %0d drain hold-offs),",
             bytes_taken, holdoffs);
    $display("%0d frames decoded, %0d channel transfers checked, %0d mismatches.",
             frames_decoded, channels_checked, mismatches);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
